### hw/rtl/mpq_pkg.sv
package mpq_pkg;

	typedef enum logic [1:0] {
		ST_PUSHED  = 2'd0,
		ST_POPPED  = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [15:0] node_id;
		logic [15:0] cost;
	} req_t;

	typedef struct packed {
		logic [15:0] out_node_id;
		logic [15:0] out_cost;
		status_t     status;
		logic [8:0]  count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] node_id;
		logic [15:0] cost;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/mpq_ram.sv
module mpq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/min_priority_queue.sv
// Min priority queue holding up to QUEUE_DEPTH (node_id, cost) entries in one
// single-port-write, registered-read RAM. The top slot (count-1) always holds
// the first entry of minimum cost. Each request is handled alone: a push
// writes the new entry, a pop reads the top entry, then a linear scan over
// the n entries held afterwards reads one RAM word per cycle and two writes
// swap the minimum to the top; the scan is skipped for n < 2. Pop on empty
// and push on full go straight to the result. One result per request; a
// finished result waits in an output register while the next request is
// accepted.
module min_priority_queue
	import mpq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_DATA,
		S_SCAN_START,
		S_SCAN,
		S_SWAP1,
		S_SWAP2,
		S_RESULT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [AW-1:0] cmp_idx_q;
	logic [AW-1:0] best_q;
	entry_t        best_data_q;
	entry_t        last_q;
	logic [15:0]   res_id_q;
	logic [15:0]   res_cost_q;
	status_t       res_status_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	entry_t               wdata;
	logic [AW-1:0]        raddr;
	logic [ENTRY_W-1:0]   rdata_raw;
	entry_t               rdata;
	logic                 accept;
	logic                 full;
	logic [CW-1:0]        last_idx;
	logic                 take;

	assign rdata    = entry_t'(rdata_raw);
	assign accept   = req_valid && !req_stall;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign last_idx = count_q - CW'(1);
	assign take     = (cmp_idx_q == '0) || (rdata.cost < best_data_q.cost);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = '{node_id: req.node_id, cost: req.cost};
		raddr = rd_idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				raddr = last_idx[AW-1:0];
				if (accept && req.req_type == REQ_PUSH && !full) begin
					we = 1'b1;
				end
			end
			S_SCAN_START: begin
				raddr = '0;
			end
			S_SWAP1: begin
				we    = 1'b1;
				waddr = last_idx[AW-1:0];
				wdata = best_data_q;
			end
			S_SWAP2: begin
				we    = 1'b1;
				waddr = best_q;
				wdata = last_q;
			end
			default: begin
			end
		endcase
	end

	mpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(ENTRY_W'(wdata)),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RESULT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_id_q   <= '0;
						res_cost_q <= '0;
						if (req.req_type == REQ_PUSH) begin
							if (full) begin
								res_status_q <= ST_DROPPED;
								state_q      <= S_RESULT;
							end else begin
								res_status_q <= ST_PUSHED;
								count_q      <= count_q + CW'(1);
								state_q      <= S_SCAN_START;
							end
						end else begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_RESULT;
							end else begin
								res_status_q <= ST_POPPED;
								count_q      <= last_idx;
								state_q      <= S_POP_DATA;
							end
						end
					end
				end
				S_POP_DATA: begin
					res_id_q   <= rdata.node_id;
					res_cost_q <= rdata.cost;
					state_q    <= S_SCAN_START;
				end
				S_SCAN_START: begin
					rd_idx_q  <= CW'(1);
					cmp_idx_q <= '0;
					state_q   <= (count_q < CW'(2)) ? S_RESULT : S_SCAN;
				end
				S_SCAN: begin
					if (take) begin
						best_q      <= cmp_idx_q;
						best_data_q <= rdata;
					end
					if (CW'(cmp_idx_q) == last_idx) begin
						last_q  <= rdata;
						state_q <= S_SWAP1;
					end else begin
						cmp_idx_q <= cmp_idx_q + AW'(1);
						rd_idx_q  <= rd_idx_q + CW'(1);
					end
				end
				S_SWAP1: begin
					state_q <= S_SWAP2;
				end
				S_SWAP2: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.out_node_id <= res_id_q;
						rsp_q.out_cost    <= res_cost_q;
						rsp_q.status      <= res_status_q;
						rsp_q.count       <= 9'(count_q);
						rsp_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in progress");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == 9'd0)
		else $error("pop on empty with nonzero count");

	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_PUSHED || rsp.status == ST_DROPPED)
		|-> rsp.out_node_id == 16'd0 && rsp.out_cost == 16'd0)
		else $error("push result carries entry data");

endmodule
